[rtl/rnt_pkg.sv]
// shared command codes and constants for the reward novelty table
package rnt_pkg;

    // item command codes
    typedef enum logic [1:0] {
        CMD_CHECK  = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // run count width and saturation limit
    localparam int COUNT_W = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // configuration register word addresses
    localparam logic ADDR_BIT_MODE = 1'b0;

    // control from the sequencer to the reward store
    typedef struct packed {
        logic clear_start;
        logic wr_en;
    } store_ctrl_t;

endpackage

[rtl/reward_novelty_table.sv]
// reward novelty table: per-feature best rewards, check and update runs
// byte mode visits one feature per item, bit mode one per bit (a store read-modify-write
// per feature through the single read port); an overrun or unused item ends in idle
// the result enters the output register at the end of the last item of a run, or from
// ST_WAIT once the output is free; a clear item sweeps all 256*MEM_BYTES store entries,
// one entry a cycle; reset is asynchronous, active low, and starts the same sweep;
// in_stall stays high during any sweep, configuration writes are taken as ever
module reward_novelty_table
    import rnt_pkg::*;
#(
    parameter int MEM_BYTES   = 128,
    parameter int REWARD_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // input items
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          command,
    input  logic [7:0]          ram_byte,
    input  logic signed [31:0]  reward,
    input  logic                last,
    // result items
    output logic                out_valid,
    input  logic                out_stall,
    output logic                novel,
    output logic [COUNT_W-1:0]  novelty_count,
    output logic                raised,
    output logic                overrun
);

    localparam int DEPTH = 256 * MEM_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int PCW   = $clog2(MEM_BYTES + 1);
    localparam int PIW   = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
    localparam int WB    = (REWARD_BITS > 32) ? REWARD_BITS : 32;
    localparam logic signed [WB-1:0] RMAX =
        {{(WB - REWARD_BITS + 1){1'b0}}, {(REWARD_BITS - 1){1'b1}}};
    localparam logic signed [WB-1:0] RMIN = ~RMAX;
    localparam logic [PCW-1:0] POS_END = PCW'(MEM_BYTES);
    localparam logic [2:0]     FEAT_LAST = 3'd7;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VISIT,
        ST_WAIT
    } state_t;

    // feature entry address
    function automatic logic [AW-1:0] feat_addr(input logic [PIW-1:0] p,
                                                input logic [7:0] b,
                                                input logic m,
                                                input logic [2:0] j);
        logic [AW-1:0] a;
        if (m)
            a = AW'({p, j, b[j]});
        else
            a = AW'({p, b});
        return a;
    endfunction

    state_t                   state_reg, state_next;
    logic                     bit_mode_reg;
    logic [PCW-1:0]           pos_reg, pos_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic                     raised_reg, raised_next;
    logic                     overrun_reg, overrun_next;
    logic signed [REWARD_BITS-1:0] r_reg, r_next;
    logic [7:0]               byte_reg, byte_next;
    logic [PIW-1:0]           pidx_reg, pidx_next;
    logic                     upd_reg, upd_next;
    logic                     last_reg, last_next;
    logic [2:0]               vis_reg, vis_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     novel_reg, novel_next;
    logic [COUNT_W-1:0]       ncount_reg, ncount_next;
    logic                     oraised_reg, oraised_next;
    logic                     ooverrun_reg, ooverrun_next;

    logic                     accept;
    logic                     out_free;
    logic                     res_load;
    logic                     done;
    logic                     done_last;
    logic                     hit;
    logic signed [WB-1:0]     r_ext;
    logic signed [WB-1:0]     r_clip;
    logic signed [REWARD_BITS-1:0] rd_val;
    logic [REWARD_BITS-1:0]   rd_data;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic                     store_busy;
    store_ctrl_t              ctrl;
    cmd_t                     cmd;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[2] == ADDR_BIT_MODE)
        begin
            bit_mode_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_BIT_MODE) ? {31'd0, bit_mode_reg} : 32'd0;

    // reward saturation to the store width
    always_comb
    begin
        r_ext = WB'(reward);
        if (r_ext > RMAX)
            r_clip = RMAX;
        else if (r_ext < RMIN)
            r_clip = RMIN;
        else
            r_clip = r_ext;
    end

    // handshake
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cmd       = cmd_t'(command);

    // store access
    assign rd_val  = rd_data;
    assign hit     = (state_reg == ST_VISIT) && (r_reg > rd_val);
    assign wr_addr = feat_addr(pidx_reg, byte_reg, bit_mode_reg, vis_reg);
    assign rd_addr = (state_reg == ST_VISIT)
                   ? feat_addr(pidx_reg, byte_reg, bit_mode_reg, vis_reg + 3'd1)
                   : feat_addr(pos_reg[PIW-1:0], ram_byte, bit_mode_reg, 3'd0);

    rnt_store #(
        .DEPTH (DEPTH),
        .W     (REWARD_BITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_addr (wr_addr),
        .wr_data (r_reg),
        .busy    (store_busy)
    );

    // sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        count_next       = count_reg;
        raised_next      = raised_reg;
        overrun_next     = overrun_reg;
        r_next           = r_reg;
        byte_next        = byte_reg;
        pidx_next        = pidx_reg;
        upd_next         = upd_reg;
        last_next        = last_reg;
        vis_next         = vis_reg;
        novel_next       = novel_reg;
        ncount_next      = ncount_reg;
        oraised_next     = oraised_reg;
        ooverrun_next    = ooverrun_reg;
        ctrl.clear_start = 1'b0;
        ctrl.wr_en       = 1'b0;
        res_load         = 1'b0;
        done             = 1'b0;
        done_last        = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!store_busy)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_CLEAR:
                        begin
                            ctrl.clear_start = 1'b1;
                            pos_next         = '0;
                            count_next       = '0;
                            raised_next      = 1'b0;
                            overrun_next     = 1'b0;
                            state_next       = ST_CLEAR;
                        end
                        CMD_NONE:
                        begin
                        end
                        CMD_CHECK, CMD_UPDATE:
                        begin
                            r_next    = r_clip[REWARD_BITS-1:0];
                            byte_next = ram_byte;
                            pidx_next = pos_reg[PIW-1:0];
                            upd_next  = (cmd == CMD_UPDATE);
                            last_next = last;
                            vis_next  = 3'd0;
                            if (pos_reg < POS_END)
                            begin
                                pos_next   = pos_reg + PCW'(1);
                                state_next = ST_VISIT;
                            end
                            else
                            begin
                                overrun_next = 1'b1;
                                done         = 1'b1;
                                done_last    = last;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_VISIT:
            begin
                // compare the entry read last cycle and raise it on update
                if (hit)
                begin
                    if (count_reg != COUNT_MAX)
                        count_next = count_reg + COUNT_W'(1);
                    if (upd_reg)
                    begin
                        ctrl.wr_en  = 1'b1;
                        raised_next = 1'b1;
                    end
                end
                if (bit_mode_reg && vis_reg != FEAT_LAST)
                begin
                    vis_next = vis_reg + 3'd1;
                end
                else
                begin
                    done       = 1'b1;
                    done_last  = last_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // end of a run: hand the result to the output register, or wait while it is still held
        if (done && done_last)
        begin
            if (out_free)
                res_load = 1'b1;
            else
                state_next = ST_WAIT;
        end

        if (res_load)
        begin
            novel_next    = (count_next != '0);
            ncount_next   = count_next;
            oraised_next  = raised_next;
            ooverrun_next = overrun_next;
            pos_next      = '0;
            count_next    = '0;
            raised_next   = 1'b0;
            overrun_next  = 1'b0;
        end

        out_valid_next = res_load || (out_valid_reg && out_stall);
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pos_reg       <= '0;
            count_reg     <= '0;
            raised_reg    <= 1'b0;
            overrun_reg   <= 1'b0;
            r_reg         <= '0;
            byte_reg      <= '0;
            pidx_reg      <= '0;
            upd_reg       <= 1'b0;
            last_reg      <= 1'b0;
            vis_reg       <= '0;
            out_valid_reg <= 1'b0;
            novel_reg     <= 1'b0;
            ncount_reg    <= '0;
            oraised_reg   <= 1'b0;
            ooverrun_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            raised_reg    <= raised_next;
            overrun_reg   <= overrun_next;
            r_reg         <= r_next;
            byte_reg      <= byte_next;
            pidx_reg      <= pidx_next;
            upd_reg       <= upd_next;
            last_reg      <= last_next;
            vis_reg       <= vis_next;
            out_valid_reg <= out_valid_next;
            novel_reg     <= novel_next;
            ncount_reg    <= ncount_next;
            oraised_reg   <= oraised_next;
            ooverrun_reg  <= ooverrun_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign novel         = novel_reg;
    assign novelty_count = ncount_reg;
    assign raised        = oraised_reg;
    assign overrun       = ooverrun_reg;

    // no item enters while the store is being swept
    a_stall_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> in_stall)
        else $error("item accepted during store sweep");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> !(out_valid_reg && out_stall))
        else $error("pending result overwritten");

    // store writes only while visiting a feature
    a_write_in_visit: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_en |-> (state_reg == ST_VISIT && upd_reg && !store_busy))
        else $error("store write outside a feature visit");

    // byte mode visits one feature only
    a_byte_one_visit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VISIT && !bit_mode_reg) |-> vis_reg == 3'd0)
        else $error("extra feature visit in byte mode");

endmodule

[rtl/rnt_store.sv]
// reward store memory with registered read and clearing sweep
module rnt_store
    import rnt_pkg::*;
#(
    parameter int DEPTH = 32768,
    parameter int W     = 32,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  store_ctrl_t   ctrl,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    output logic          busy
);

    localparam logic [W-1:0]  REWARD_LOW = {1'b1, {(W-1){1'b0}}};
    localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);

    logic [W-1:0]  mem [DEPTH];
    logic [W-1:0]  rd_data_reg;
    logic          busy_reg;
    logic          busy_next;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [W-1:0]  mem_wdata;

    // clearing sweep, one entry a cycle
    always_comb
    begin
        busy_next = busy_reg;
        ptr_next  = ptr_reg;
        if (ctrl.clear_start)
        begin
            busy_next = 1'b1;
            ptr_next  = '0;
        end
        else if (busy_reg)
        begin
            if (ptr_reg == LAST_ADDR)
            begin
                busy_next = 1'b0;
                ptr_next  = '0;
            end
            else
            begin
                ptr_next = ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            ptr_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            ptr_reg  <= ptr_next;
        end
    end

    // write port shared by the sweep and the sequencer
    assign mem_we    = busy_reg || ctrl.wr_en;
    assign mem_waddr = busy_reg ? ptr_reg : wr_addr;
    assign mem_wdata = busy_reg ? REWARD_LOW : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule
